### src/assert_macros.svh
// assertion macros shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// property must hold at every clock edge outside reset
`define ASSERT_PROP(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");
// expression must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define ASSERT_PROP(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

### src/blrp_pkg.sv
// shared types and constants of the ldap response parser
`timescale 1ns / 1ps

package blrp_pkg;

    localparam int LENGTH_WIDTH_DEFAULT = 32;

    localparam logic [7:0] TAG_SEQUENCE   = 8'h30;
    localparam logic [7:0] TAG_INTEGER    = 8'h02;
    localparam logic [7:0] TAG_ENUMERATED = 8'h0a;
    localparam logic [7:0] TAG_BIND_RSP   = 8'h61;
    localparam logic [7:0] TAG_EXT_RSP    = 8'h78;

    localparam int APB_ADDR_WIDTH = 3;
    localparam logic [0:0] REG_OP_TAG   = 1'b0;
    localparam logic [7:0] OP_TAG_RESET = TAG_BIND_RSP;

    localparam logic STATUS_OK    = 1'b0;
    localparam logic STATUS_ERROR = 1'b1;

    typedef struct packed {
        logic        status;
        logic [31:0] res_code;
    } t_rsp;

    typedef struct packed {
        logic valid;
        t_rsp rsp;
    } t_result;

endpackage

### src/blrp_stream_if.sv
// valid/ready stream interfaces for response bytes and parse results
`timescale 1ns / 1ps

interface blrp_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last;

    modport source (output valid, output data_byte, output last, input ready);
    modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface blrp_result_if;
    logic        valid;
    logic        ready;
    logic        status;
    logic [31:0] res_code;

    modport source (output valid, output status, output res_code, input ready);
    modport sink   (input valid, input status, input res_code, output ready);
endinterface

### src/blrp_cfg_regs.sv
// apb register file holding the expected operation tag
`timescale 1ns / 1ps

module blrp_cfg_regs (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [blrp_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready,
    output logic [7:0]                          o_op_tag
);
    import blrp_pkg::*;

    logic [7:0] r_op_tag;
    logic       wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_op_tag <= OP_TAG_RESET;
        end else if (wr_en && paddr[2] == REG_OP_TAG) begin
            r_op_tag <= pwdata[7:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == REG_OP_TAG) begin
            prdata = {24'd0, r_op_tag};
        end
    end

    assign o_op_tag = r_op_tag;

endmodule

### src/blrp_parser.sv
// byte-wise ber walker producing one result per message
`timescale 1ns / 1ps

`include "assert_macros.svh"

module blrp_parser #(
    parameter int LENGTH_WIDTH = blrp_pkg::LENGTH_WIDTH_DEFAULT
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last,
    input  logic [7:0]        i_op_tag,
    output blrp_pkg::t_result o_result
);
    import blrp_pkg::*;

    typedef enum logic [3:0] {
        PH_SEQ_TAG, PH_SEQ_LEN, PH_ID_TAG, PH_ID_LEN, PH_ID_SKIP, PH_OP_TAG,
        PH_OP_LEN, PH_ENUM_TAG, PH_ENUM_LEN, PH_CODE, PH_DONE
    } t_phase;

    localparam logic [LENGTH_WIDTH-1:0] LEN_ONE = {{(LENGTH_WIDTH-1){1'b0}}, 1'b1};

    t_phase                  r_phase, n_phase;
    logic [LENGTH_WIDTH-1:0] r_len, n_len;
    logic [6:0]              r_len_left, n_len_left;
    logic [31:0]             r_code, n_code;
    logic                    r_seen, n_seen;

    // length byte decode, shared by every length phase
    logic                    lf_done;
    logic [LENGTH_WIDTH-1:0] lf_len;
    logic [6:0]              lf_left;
    logic [LENGTH_WIDTH-1:0] len_dec;

    logic        err, emit;
    logic [31:0] code;

    always_comb begin
        lf_len  = r_len;
        lf_left = r_len_left;
        lf_done = 1'b0;
        if (r_len_left == 7'd0) begin
            if (!i_data_byte[7]) begin
                lf_len  = {{(LENGTH_WIDTH-8){1'b0}}, i_data_byte};
                lf_done = 1'b1;
            end else begin
                // long form, 0x80 (indefinite) ends at once with length zero
                lf_len  = '0;
                lf_left = i_data_byte[6:0];
                lf_done = (i_data_byte[6:0] == 7'd0);
            end
        end else begin
            if (r_len[LENGTH_WIDTH-1 -: 8] != 8'd0) begin
                lf_len = '1;
            end else begin
                lf_len = {r_len[LENGTH_WIDTH-9:0], i_data_byte};
            end
            lf_left = r_len_left - 7'd1;
            lf_done = (lf_left == 7'd0);
        end
    end

    assign len_dec = r_len - LEN_ONE;

    always_comb begin
        n_phase    = r_phase;
        n_len      = r_len;
        n_len_left = r_len_left;
        n_code     = r_code;
        n_seen     = r_seen;
        err        = 1'b0;
        emit       = 1'b0;
        code       = 32'd0;

        case (r_phase)
            PH_SEQ_TAG: begin
                if (i_data_byte == TAG_SEQUENCE) n_phase = PH_SEQ_LEN;
                else err = 1'b1;
            end
            PH_SEQ_LEN: begin
                n_len      = lf_len;
                n_len_left = lf_left;
                if (lf_done) n_phase = PH_ID_TAG;
            end
            PH_ID_TAG: begin
                if (i_data_byte == TAG_INTEGER) n_phase = PH_ID_LEN;
                else err = 1'b1;
            end
            PH_ID_LEN: begin
                n_len      = lf_len;
                n_len_left = lf_left;
                if (lf_done) n_phase = (lf_len == '0) ? PH_OP_TAG : PH_ID_SKIP;
            end
            PH_ID_SKIP: begin
                n_len = len_dec;
                if (len_dec == '0) n_phase = PH_OP_TAG;
            end
            PH_OP_TAG: begin
                if (i_data_byte == i_op_tag) n_phase = PH_OP_LEN;
                else err = 1'b1;
            end
            PH_OP_LEN: begin
                n_len      = lf_len;
                n_len_left = lf_left;
                if (lf_done) n_phase = PH_ENUM_TAG;
            end
            PH_ENUM_TAG: begin
                if (i_data_byte == TAG_ENUMERATED) n_phase = PH_ENUM_LEN;
                else err = 1'b1;
            end
            PH_ENUM_LEN: begin
                n_len      = lf_len;
                n_len_left = lf_left;
                if (lf_done) begin
                    if (lf_len == '0) begin
                        err = 1'b1;
                    end else begin
                        n_phase = PH_CODE;
                        n_code  = 32'd0;
                        n_seen  = 1'b0;
                    end
                end
            end
            PH_CODE: begin
                n_code = {r_code[23:0], i_data_byte};
                n_seen = 1'b1;
                n_len  = len_dec;
                if (len_dec == '0) begin
                    emit    = 1'b1;
                    code    = n_code;
                    n_phase = PH_DONE;
                end
            end
            default: begin
            end
        endcase

        if (err) begin
            emit    = 1'b1;
            n_phase = PH_DONE;
        end

        // message ended before a result went out
        if (i_last && !emit && n_phase != PH_DONE) begin
            emit = 1'b1;
            if (n_phase == PH_CODE && n_seen) code = n_code;
            else err = 1'b1;
        end

        if (i_last) begin
            n_phase    = PH_SEQ_TAG;
            n_len      = '0;
            n_len_left = 7'd0;
            n_code     = 32'd0;
            n_seen     = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase    <= PH_SEQ_TAG;
            r_len      <= '0;
            r_len_left <= 7'd0;
            r_code     <= 32'd0;
            r_seen     <= 1'b0;
        end else if (i_accept) begin
            r_phase    <= n_phase;
            r_len      <= n_len;
            r_len_left <= n_len_left;
            r_code     <= n_code;
            r_seen     <= n_seen;
        end
    end

    assign o_result.valid        = i_accept && emit;
    assign o_result.rsp.status   = err ? STATUS_ERROR : STATUS_OK;
    assign o_result.rsp.res_code = err ? 32'd0 : code;

    `ASSERT_PROP(a_last_restarts, i_clk, i_rst_n, (i_accept && i_last) |=> r_phase == PH_SEQ_TAG)
    `ASSERT_PROP(a_done_silent, i_clk, i_rst_n,
                 (i_accept && !i_last && r_phase == PH_DONE) |-> !o_result.valid)
    `ASSERT_PROP(a_error_zero_code, i_clk, i_rst_n,
                 (o_result.valid && o_result.rsp.status == STATUS_ERROR)
                 |-> o_result.rsp.res_code == 32'd0)

endmodule

### src/blrp_out_queue.sv
// two-entry result queue between parser and result channel
`timescale 1ns / 1ps

`include "assert_macros.svh"

module blrp_out_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  blrp_pkg::t_result i_push,
    input  logic              i_pop_ready,
    output logic              o_valid,
    output blrp_pkg::t_rsp    o_head,
    output logic              o_has_room
);
    import blrp_pkg::*;

    t_rsp       r_q [2];
    logic [1:0] r_count;
    logic       push, pop;

    assign push       = i_push.valid;
    assign o_valid    = (r_count != 2'd0);
    assign pop        = o_valid && i_pop_ready;
    assign o_has_room = (r_count != 2'd2);
    assign o_head     = r_q[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= 2'd0;
        end else begin
            if (push && !pop) r_count <= r_count + 2'd1;
            else if (pop && !push) r_count <= r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            // head either takes the new entry or the one behind it
            if (push && r_count == 2'd1) r_q[0] <= i_push.rsp;
            else r_q[0] <= r_q[1];
            if (push && r_count != 2'd1) r_q[1] <= i_push.rsp;
        end else if (push) begin
            r_q[r_count[0]] <= i_push.rsp;
        end
    end

    `ASSERT_NEVER(a_no_overflow, i_clk, i_rst_n, r_count == 2'd3)
    `ASSERT_PROP(a_push_has_room, i_clk, i_rst_n, push |-> (r_count != 2'd2 || pop))
    `ASSERT_PROP(a_shift_on_pop, i_clk, i_rst_n,
                 (pop && !push && r_count == 2'd2) |=> o_head == $past(r_q[1]))

endmodule

### src/ber_ldap_response_parser.sv
// top level of the ber ldap response result-code parser
`timescale 1ns / 1ps

// usage
//   i_req carries response bytes (data_byte, last marks the final byte of a
//   message); o_rsp carries one result per message: status 0 with the low
//   32 bits of the result code, or status 1 (parse error) with code zero
//   the apb port holds one register, the operation tag at byte address 0
//   (operation tag to match, reset 0x61); write it only while idle
// timing
//   one byte is taken every cycle while the queue has room; the parser state
//   registers are updated in the accept cycle and a result is registered in
//   the queue, shown on o_rsp behind older results; throughput is one byte per
//   cycle while the queue has room, set by the single registered parser step
// stall behavior
//   results pass through a two-entry queue, so bytes keep flowing while one
//   result waits; i_req.ready drops only when both entries are full
// reset
//   synchronous, active low: parser back to expecting the sequence tag,
//   queue emptied, operation tag back to 0x61

module ber_ldap_response_parser #(
    parameter int LENGTH_WIDTH = blrp_pkg::LENGTH_WIDTH_DEFAULT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    blrp_byte_if.sink                           i_req,
    blrp_result_if.source                       o_rsp,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [blrp_pkg::APB_ADDR_WIDTH-1:0] paddr,
    input  logic [31:0]                         pwdata,
    output logic [31:0]                         prdata,
    output logic                                pready
);
    import blrp_pkg::*;

    logic       tag_nonzero;
    logic [7:0] op_tag_val;
    logic       accept;
    logic       has_room;
    t_result    result;
    t_rsp       head;

    // configuration registers
    blrp_cfg_regs u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_op_tag (op_tag_val)
    );

    // a request is taken whenever the result queue can absorb what it causes
    assign i_req.ready = has_room;
    assign accept      = i_req.valid && has_room;
    assign tag_nonzero = |op_tag_val;

    // single-step ber walker
    blrp_parser #(
        .LENGTH_WIDTH (LENGTH_WIDTH)
    ) u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_req.data_byte),
        .i_last      (i_req.last),
        .i_op_tag    (op_tag_val),
        .o_result    (result)
    );

    // result queue, decouples the byte stream from result back-pressure
    blrp_out_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (result),
        .i_pop_ready (o_rsp.ready),
        .o_valid     (o_rsp.valid),
        .o_head      (head),
        .o_has_room  (has_room)
    );

    assign o_rsp.status   = head.status;
    assign o_rsp.res_code = head.res_code;

    `ASSERT_PROP(a_result_needs_accept, i_clk, i_rst_n, result.valid |-> accept)
    `ASSERT_PROP(a_tag_reset_value, i_clk, i_rst_n,
                 $past(!i_rst_n) |-> (tag_nonzero && op_tag_val == TAG_BIND_RSP))
    `ASSERT_PROP(a_stall_keeps_result, i_clk, i_rst_n,
                 (o_rsp.valid && !o_rsp.ready) |=> o_rsp.valid)

endmodule

### bench/ber_ldap_response_parser_tb.sv
// self-checking testbench of the ber ldap response parser: directed table, then random messages
`timescale 1ns / 1ps

module ber_ldap_response_parser_tb;
    import blrp_pkg::*;

    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 9;
    // settling margin for the registered result and the two-entry result queue
    localparam int SETTLE_CYCLES = 8;
    localparam int SEG_ITEMS     = 292;
    localparam int NUM_SEGMENTS  = 6;
    localparam int TIMEOUT_NS    = 5_000_000;
    localparam int LW            = LENGTH_WIDTH_DEFAULT;

    localparam logic [APB_ADDR_WIDTH-1:0] TAG_ADDR      = APB_ADDR_WIDTH'(4 * REG_OP_TAG);
    localparam logic [APB_ADDR_WIDTH-1:0] UNMAPPED_ADDR = TAG_ADDR + APB_ADDR_WIDTH'(4);

    // ber length octet: top bit set means long form, low bits count the octets
    localparam logic [7:0] LEN_LONG = 8'h80;

    // parser walk through one response message
    typedef enum logic [3:0] {
        P_SEQ_TAG, P_SEQ_LEN, P_ID_TAG, P_ID_LEN, P_ID_SKIP,
        P_OP_TAG, P_OP_LEN, P_ENUM_TAG, P_ENUM_LEN, P_CODE, P_DONE
    } t_phase;

    // one row of the directed table; typed rows carry the result they must cause
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last;
        logic        typed;
        logic        status;
        logic [31:0] code;
    } t_row;

    localparam t_row DIRECTED_ROWS [22] = '{
        // wrong sequence tag at both ends of the byte range
        '{8'h00, 1'b1, 1'b1, STATUS_ERROR, 32'h0},
        '{8'hff, 1'b1, 1'b1, STATUS_ERROR, 32'h0},
        // message ends right after the sequence tag
        '{TAG_SEQUENCE, 1'b1, 1'b1, STATUS_ERROR, 32'h0},
        // long-form sequence length, empty message id, indefinite op length,
        // then an indefinite code length, which reads as zero and is an error
        '{TAG_SEQUENCE,   1'b0, 1'b0, STATUS_OK, 32'h0},
        '{8'h81,          1'b0, 1'b0, STATUS_OK, 32'h0},
        '{8'h05,          1'b0, 1'b0, STATUS_OK, 32'h0},
        '{TAG_INTEGER,    1'b0, 1'b0, STATUS_OK, 32'h0},
        '{8'h00,          1'b0, 1'b0, STATUS_OK, 32'h0},
        '{TAG_BIND_RSP,   1'b0, 1'b0, STATUS_OK, 32'h0},
        '{LEN_LONG,       1'b0, 1'b0, STATUS_OK, 32'h0},
        '{TAG_ENUMERATED, 1'b0, 1'b0, STATUS_OK, 32'h0},
        '{LEN_LONG,       1'b1, 1'b1, STATUS_ERROR, 32'h0},
        // two code bytes announced, message ends after the first: partial code
        '{TAG_SEQUENCE,   1'b0, 1'b0, STATUS_OK, 32'h0},
        '{8'h06,          1'b0, 1'b0, STATUS_OK, 32'h0},
        '{TAG_INTEGER,    1'b0, 1'b0, STATUS_OK, 32'h0},
        '{8'h01,          1'b0, 1'b0, STATUS_OK, 32'h0},
        '{8'h7f,          1'b0, 1'b0, STATUS_OK, 32'h0},
        '{TAG_BIND_RSP,   1'b0, 1'b0, STATUS_OK, 32'h0},
        '{8'h00,          1'b0, 1'b0, STATUS_OK, 32'h0},
        '{TAG_ENUMERATED, 1'b0, 1'b0, STATUS_OK, 32'h0},
        '{8'h02,          1'b0, 1'b0, STATUS_OK, 32'h0},
        '{8'h12,          1'b1, 1'b1, STATUS_OK, 32'h12}
    };

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [APB_ADDR_WIDTH-1:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    blrp_byte_if   req_if ();
    blrp_result_if rsp_if ();

    // side band that travels with each request: a typed expectation from the table
    logic req_typed;
    t_rsp req_exp;

    // parser model state
    t_phase         ph;
    logic [LW-1:0]  len_val;
    logic [6:0]     len_left;
    logic [31:0]    code_acc;
    logic           code_seen;
    logic [7:0]     cfg_tag;

    t_rsp rsp_expected_q [$];
    logic [7:0] msg_q [$];

    int send_idle_pct;
    int recv_idle_pct;
    int n_fail;
    int n_requests;
    int n_results;
    int n_parse_errors;
    int n_settings;

    ber_ldap_response_parser uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #HALF_PERIOD i_clk = 1'b1;
        #HALF_PERIOD i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // parser model
    // ------------------------------------------------------------------

    function automatic void clear_parser();
        ph        = P_SEQ_TAG;
        len_val   = '0;
        len_left  = '0;
        code_acc  = '0;
        code_seen = 1'b0;
    endfunction

    // one ber length octet; returns 1 once the whole length is known
    function automatic bit feed_length(input logic [7:0] b);
        if (len_left == 0) begin
            if (!b[7]) begin
                len_val = LW'(b);
                return 1'b1;
            end
            // long form; a zero count is the indefinite form and reads as 0
            len_val  = '0;
            len_left = b[6:0];
            return len_left == 0;
        end
        // saturate rather than wrap once another octet would overflow
        if (len_val > ({LW{1'b1}} >> 8))
            len_val = {LW{1'b1}};
        else
            len_val = (len_val << 8) | LW'(b);
        len_left = len_left - 7'd1;
        return len_left == 0;
    endfunction

    // advance the model by one byte; returns 1 when the byte yields a result
    function automatic bit parse_step(input logic [7:0] b, input logic l, output t_rsp r);
        bit          emit;
        bit          err;
        logic [31:0] code;
        emit = 1'b0;
        err  = 1'b0;
        code = '0;
        case (ph)
            P_SEQ_TAG: begin
                if (b == TAG_SEQUENCE) ph = P_SEQ_LEN;
                else err = 1'b1;
            end
            P_SEQ_LEN: begin
                if (feed_length(b)) ph = P_ID_TAG;
            end
            P_ID_TAG: begin
                if (b == TAG_INTEGER) ph = P_ID_LEN;
                else err = 1'b1;
            end
            P_ID_LEN: begin
                if (feed_length(b)) ph = (len_val == 0) ? P_OP_TAG : P_ID_SKIP;
            end
            P_ID_SKIP: begin
                // message id value is not interpreted
                len_val = len_val - 1'b1;
                if (len_val == 0) ph = P_OP_TAG;
            end
            P_OP_TAG: begin
                if (b == cfg_tag) ph = P_OP_LEN;
                else err = 1'b1;
            end
            P_OP_LEN: begin
                if (feed_length(b)) ph = P_ENUM_TAG;
            end
            P_ENUM_TAG: begin
                if (b == TAG_ENUMERATED) ph = P_ENUM_LEN;
                else err = 1'b1;
            end
            P_ENUM_LEN: begin
                if (feed_length(b)) begin
                    // an empty result code is a parse error
                    if (len_val == 0) begin
                        err = 1'b1;
                    end else begin
                        ph        = P_CODE;
                        code_acc  = '0;
                        code_seen = 1'b0;
                    end
                end
            end
            P_CODE: begin
                // big-endian, only the low 32 bits survive
                code_acc  = {code_acc[23:0], b};
                code_seen = 1'b1;
                len_val   = len_val - 1'b1;
                if (len_val == 0) begin
                    emit = 1'b1;
                    code = code_acc;
                    ph   = P_DONE;
                end
            end
            default: begin
            end
        endcase
        if (err) begin
            emit = 1'b1;
            ph   = P_DONE;
        end
        // early end: partial code once a code byte came, else a parse error
        if (l && !emit && ph != P_DONE) begin
            emit = 1'b1;
            if (ph == P_CODE && code_seen) code = code_acc;
            else err = 1'b1;
        end
        if (l) clear_parser();
        r.status   = err ? STATUS_ERROR : STATUS_OK;
        r.res_code = err ? 32'h0 : code;
        return emit;
    endfunction

    // ------------------------------------------------------------------
    // monitor: model update on accepted requests, check of accepted results
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin : monitor
        t_rsp pred;
        t_rsp got;
        bit   fires;
        if (!i_rst_n) begin
            clear_parser();
            cfg_tag = OP_TAG_RESET;
        end else begin
            if (psel && penable && pwrite && pready && paddr == TAG_ADDR)
                cfg_tag = pwdata[7:0];
            if (req_if.valid && req_if.ready) begin
                n_requests++;
                fires = parse_step(req_if.data_byte, req_if.last, pred);
                // table rows with a typed result take it instead of the model's
                if (req_typed) rsp_expected_q.push_back(req_exp);
                else if (fires) rsp_expected_q.push_back(pred);
            end
            if (rsp_if.valid && rsp_if.ready) begin
                got.status   = rsp_if.status;
                got.res_code = rsp_if.res_code;
                n_results++;
                if (got.status == STATUS_ERROR) n_parse_errors++;
                if (rsp_expected_q.size() == 0) begin
                    $error("result with no request pending: status %0d, res_code 0x%08h",
                           got.status, got.res_code);
                    n_fail++;
                end else begin
                    pred = rsp_expected_q.pop_front();
                    if (got.status !== pred.status) begin
                        $error("status mismatch: expected %0d, actual %0d",
                               pred.status, got.status);
                        n_fail++;
                    end
                    if (got.res_code !== pred.res_code) begin
                        $error("res_code mismatch: expected 0x%08h, actual 0x%08h",
                               pred.res_code, got.res_code);
                        n_fail++;
                    end
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge i_clk) begin
        rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // ------------------------------------------------------------------
    // drivers
    // ------------------------------------------------------------------

    task automatic send_item(input logic [7:0] b, input logic l, input logic typed,
                             input t_rsp r);
        while ($urandom_range(99) < send_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid     <= 1'b1;
        req_if.data_byte <= b;
        req_if.last      <= l;
        req_typed        <= typed;
        req_exp          <= r;
        @(posedge i_clk);
        while (!req_if.ready) @(posedge i_clk);
    endtask

    task automatic send_message();
        for (int i = 0; i < msg_q.size(); i++)
            send_item(msg_q[i], i == msg_q.size() - 1, 1'b0, '0);
    endtask

    // hold off until every result is in, then let the pipe go quiet
    task automatic wait_idle();
        req_if.valid <= 1'b0;
        while (rsp_expected_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic [APB_ADDR_WIDTH-1:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic apb_check_tag(input logic [7:0] want);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= TAG_ADDR;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        if (prdata[7:0] !== want) begin
            $error("op_tag mismatch: expected 0x%02h, actual 0x%02h", want, prdata[7:0]);
            n_fail++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // random message builder
    // ------------------------------------------------------------------

    // length encoding of an exact value, in short, long or padded long form
    function automatic void put_length(input int unsigned n);
        int unsigned nb;
        int unsigned pad;
        int unsigned k;
        nb = (n == 0) ? 0 : (n < 256) ? 1 : (n < 65536) ? 2 : 3;
        if (n < 128 && $urandom_range(1) == 1) begin
            msg_q.push_back(n[7:0]);
            return;
        end
        pad = $urandom_range(2);
        k   = nb + pad;
        // k of zero gives the indefinite form, which only stands for length 0
        msg_q.push_back(LEN_LONG | k[7:0]);
        repeat (pad) msg_q.push_back(8'h00);
        for (int i = nb - 1; i >= 0; i--) msg_q.push_back(8'(n >> (8 * i)));
    endfunction

    // length whose value the parser never uses; long runs drive saturation
    function automatic void put_any_length();
        int unsigned r;
        int unsigned k;
        r = $urandom_range(9);
        if (r < 5) begin
            msg_q.push_back(8'($urandom_range(127)));
        end else if (r == 5) begin
            msg_q.push_back(LEN_LONG);
        end else begin
            k = (r < 9) ? $urandom_range(1, 4) : $urandom_range(5, 8);
            if ($urandom_range(49) == 0) k = 127;
            msg_q.push_back(LEN_LONG | k[7:0]);
            repeat (k) msg_q.push_back(8'($urandom_range(255)));
        end
    endfunction

    // well-formed response with random content, now and then broken;
    // returns the number of bytes built, trailing junk included
    function automatic int build_response(input logic [7:0] tag);
        int unsigned id_len;
        int unsigned code_len;
        int unsigned r;
        int unsigned k;
        msg_q.delete();
        msg_q.push_back(TAG_SEQUENCE);
        put_any_length();
        msg_q.push_back(TAG_INTEGER);
        id_len = ($urandom_range(29) == 0) ? $urandom_range(5, 300) : $urandom_range(0, 4);
        put_length(id_len);
        repeat (id_len) msg_q.push_back(8'($urandom_range(255)));
        msg_q.push_back(tag);
        put_any_length();
        msg_q.push_back(TAG_ENUMERATED);
        r = $urandom_range(19);
        if (r == 0) code_len = 0;
        else if (r < 13) code_len = $urandom_range(1, 4);
        else if (r < 18) code_len = 1;
        else code_len = $urandom_range(5, 6);
        put_length(code_len);
        repeat (code_len) begin
            r = $urandom_range(7);
            msg_q.push_back(r == 0 ? 8'h00 : r == 1 ? 8'hff : 8'($urandom_range(255)));
        end
        r = $urandom_range(19);
        if (r == 0) begin
            // one byte hit by noise, anywhere
            msg_q[$urandom_range(msg_q.size() - 1)] = 8'($urandom_range(255));
        end else if (r == 1) begin
            // cut short: the last flag lands somewhere inside
            k = $urandom_range(1, msg_q.size());
            while (msg_q.size() > k) void'(msg_q.pop_back());
            return msg_q.size();
        end
        // bytes after the result are ignored up to the last one
        repeat ($urandom_range(3)) msg_q.push_back(8'($urandom_range(255)));
        return msg_q.size();
    endfunction

    // ------------------------------------------------------------------
    // stimulus
    // ------------------------------------------------------------------

    initial begin : stimulus
        t_row       row;
        logic [7:0] tag;
        int         seg_items;
        i_rst_n          = 1'b0;
        req_if.valid     = 1'b0;
        req_if.data_byte = 8'h00;
        req_if.last      = 1'b0;
        rsp_if.ready     = 1'b0;
        req_typed        = 1'b0;
        req_exp          = '0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        send_idle_pct    = 9;
        recv_idle_pct    = 76;
        n_fail           = 0;
        n_requests       = 0;
        n_results        = 0;
        n_parse_errors   = 0;
        n_settings       = 1;
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // register reset value, then the directed table under the reset tag
        apb_check_tag(OP_TAG_RESET);
        for (int i = 0; i < $size(DIRECTED_ROWS); i++) begin
            row = DIRECTED_ROWS[i];
            send_item(row.data_byte, row.last, row.typed, t_rsp'{row.status, row.code});
        end

        // random segments, each under its own tag, with one idling pattern per pair of segments;
        // the drain at each segment start also holds the sender off completely
        for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
            wait_idle();
            case (seg)
                0:       tag = TAG_EXT_RSP;
                1:       tag = 8'h00;
                2:       tag = 8'hff;
                3:       tag = TAG_BIND_RSP;
                4:       tag = TAG_SEQUENCE;
                default: tag = TAG_ENUMERATED;
            endcase
            apb_write(TAG_ADDR, {24'h0, tag});
            // a write off the register map must leave the tag alone
            if (seg == 2) apb_write(UNMAPPED_ADDR, {24'h0, TAG_SEQUENCE});
            apb_check_tag(tag);
            n_settings++;
            case (seg / 2)
                0: begin
                    send_idle_pct = 9;
                    recv_idle_pct = 76;
                end
                1: begin
                    send_idle_pct = 76;
                    recv_idle_pct = 9;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            seg_items = 0;
            while (seg_items < SEG_ITEMS) begin
                if ($urandom_range(99) < 85) begin
                    seg_items += build_response(tag);
                end else begin
                    // short burst of noise, usually a wrong sequence tag
                    msg_q.delete();
                    repeat ($urandom_range(1, 6)) msg_q.push_back(8'($urandom_range(255)));
                    seg_items += msg_q.size();
                end
                send_message();
                if ($urandom_range(24) == 0) wait_idle();
            end
        end

        wait_idle();
        $display("ran %0d request bytes over %0d tag settings and three idling patterns",
                 n_requests, n_settings);
        $display("checked %0d results, %0d of them parse errors", n_results, n_parse_errors);
        if (n_fail == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("timeout with %0d results outstanding", rsp_expected_q.size());
        $display("Test completed with failures");
        $finish;
    end

endmodule
